// ===== hw/rtl/btlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared constants of the binary trie longest prefix match block: port
// widths of the transaction fields and the command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package btlpm_pkg;

   // field widths on the request and response channels
   localparam int unsigned ADDR_PORT_W = 32;
   localparam int unsigned LEN_PORT_W  = 6;
   localparam int unsigned HOP_PORT_W  = 16;

   // request commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // response status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_POOL_FULL = 1'b1;

endpackage : btlpm_pkg

`default_nettype wire

// ===== hw/rtl/btlpm_ram.sv =====
// ----------------------------------------------------------------------------
// btlpm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btlpm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : btlpm_ram

`default_nettype wire

// ===== hw/rtl/binary_trie_longest_prefix_match_top.sv =====
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_top
// IPv4 route table held as a unibit binary trie in a node memory.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall) carries one command per
// transaction: insert a route (address, route length, hop_in) or look up an
// address. Each request gives exactly one response transaction on the
// rsp_valid / rsp_stall channel with found, hop_out and status.
// The walk visits one trie level per cycle, bounded by the single node
// memory read per level. A lookup visits up to ADDR_BITS + 1 levels, an
// insert prefix length + 1 levels, before the result waits in the done
// state. One request is in work at a time; the next request is accepted
// the cycle after the response is loaded, even while that response still
// waits to be taken.
// The root node sits in flip-flops, so reset (synchronous, active high)
// gives an empty table at once with no clearing pass. When the receiver
// stalls, the finished result waits in its own state until the response
// register is free, and the request channel stays stalled meanwhile.
// An insert that runs out of nodes answers status 1 and leaves the nodes
// already linked in, unmarked.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_longest_prefix_match_top #(
   parameter int unsigned POOL_NODES = 1024,
   parameter int unsigned HOP_WIDTH  = 16,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_command,
   input  wire logic [btlpm_pkg::ADDR_PORT_W-1:0]     req_address,
   input  wire logic [btlpm_pkg::LEN_PORT_W-1:0]      req_route_len,
   input  wire logic [btlpm_pkg::HOP_PORT_W-1:0]      req_hop_in,
   // response channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_found,
   output      logic [btlpm_pkg::HOP_PORT_W-1:0]      rsp_hop_out,
   output      logic                                  rsp_status
);

   localparam int unsigned IDX_W   = $clog2(POOL_NODES);
   localparam int unsigned CNT_W   = $clog2(POOL_NODES + 1);
   localparam int unsigned DEPTH_W = $clog2(ADDR_BITS + 1);
   localparam int unsigned ENTRY_W = 2 * IDX_W + 1 + HOP_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // control state
   state_type               state_ff,     state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        next_free_ff, next_free_in;
   logic [IDX_W-1:0]        root_zero_ff, root_zero_in;
   logic [IDX_W-1:0]        root_one_ff,  root_one_in;
   logic                    root_mark_ff, root_mark_in;

   // payload state
   logic [HOP_WIDTH-1:0]    root_hop_ff,  root_hop_in;
   logic                    cmd_ff,       cmd_in;
   logic [ADDR_BITS-1:0]    addr_ff,      addr_in;
   logic [DEPTH_W-1:0]      len_ff,       len_in;
   logic [DEPTH_W-1:0]      depth_ff,     depth_in;
   logic [HOP_WIDTH-1:0]    hop_ff,       hop_in;
   logic [IDX_W-1:0]        node_ff,      node_in;
   logic                    fresh_ff,     fresh_in;
   logic                    found_ff,     found_in;
   logic [HOP_WIDTH-1:0]    best_ff,      best_in;
   logic                    status_ff,    status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [btlpm_pkg::HOP_PORT_W-1:0] rsp_hop_ff, rsp_hop_in;
   logic                    rsp_status_ff, rsp_status_in;

   // node memory port
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;

   // view of the current node
   logic [IDX_W-1:0]        cur_zero;
   logic [IDX_W-1:0]        cur_one;
   logic                    cur_mark;
   logic [HOP_WIDTH-1:0]    cur_hop;
   logic                    step_bit;
   logic [IDX_W-1:0]        nxt;
   logic [IDX_W-1:0]        alloc_node;
   logic [DEPTH_W-1:0]      req_len;

   btlpm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (POOL_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // current node: root from flip-flops, a node made in this insert is
   // known empty, any other comes from the memory read of last cycle
   always_comb begin
      if (node_ff == '0) begin
         cur_zero = root_zero_ff;
         cur_one  = root_one_ff;
         cur_mark = root_mark_ff;
         cur_hop  = root_hop_ff;
      end else if (fresh_ff) begin
         cur_zero = '0;
         cur_one  = '0;
         cur_mark = 1'b0;
         cur_hop  = '0;
      end else begin
         {cur_zero, cur_one, cur_mark, cur_hop} = ram_rd_data;
      end
   end

   assign step_bit   = addr_ff[ADDR_BITS-1];
   assign nxt        = step_bit ? cur_one : cur_zero;
   assign alloc_node = next_free_ff[IDX_W-1:0];

   // prefix length clamped to the address width
   assign req_len = (req_route_len > btlpm_pkg::LEN_PORT_W'(ADDR_BITS))
                    ? DEPTH_W'(ADDR_BITS) : req_route_len[DEPTH_W-1:0];

   // next state and memory control
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      next_free_in  = next_free_ff;
      root_zero_in  = root_zero_ff;
      root_one_in   = root_one_ff;
      root_mark_in  = root_mark_ff;
      root_hop_in   = root_hop_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      depth_in      = depth_ff;
      hop_in        = hop_ff;
      node_in       = node_ff;
      fresh_in      = fresh_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_hop_in    = rsp_hop_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = node_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = node_ff;

      // response taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               addr_in   = req_address[ADDR_BITS-1:0];
               len_in    = req_len;
               hop_in    = HOP_WIDTH'(req_hop_in);
               node_in   = '0;
               depth_in  = '0;
               fresh_in  = 1'b0;
               found_in  = 1'b0;
               best_in   = '0;
               status_in = btlpm_pkg::STATUS_OK;
               state_in  = ST_WALK;
            end
         end

         ST_WALK: begin
            if (cmd_ff == btlpm_pkg::CMD_LOOKUP) begin
               // remember the deepest marked node passed
               if (cur_mark) begin
                  found_in = 1'b1;
                  best_in  = cur_hop;
               end
               if (depth_ff == DEPTH_W'(ADDR_BITS) || nxt == '0) begin
                  state_in = ST_DONE;
               end else begin
                  node_in     = nxt;
                  ram_rd_addr = nxt;
                  depth_in    = depth_ff + 1'b1;
                  addr_in     = addr_ff << 1;
               end
            end else begin
               if (depth_ff == len_ff) begin
                  // mark the prefix node and store its hop
                  if (node_ff == '0) begin
                     root_mark_in = 1'b1;
                     root_hop_in  = hop_ff;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {cur_zero, cur_one, 1'b1, hop_ff};
                  end
                  state_in = ST_DONE;
               end else if (nxt != '0) begin
                  // existing child
                  node_in     = nxt;
                  ram_rd_addr = nxt;
                  depth_in    = depth_ff + 1'b1;
                  addr_in     = addr_ff << 1;
               end else if (next_free_ff == CNT_W'(POOL_NODES)) begin
                  // pool exhausted: leave a linked new node empty
                  status_in = btlpm_pkg::STATUS_POOL_FULL;
                  if (fresh_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = '0;
                  end
                  state_in = ST_DONE;
               end else begin
                  // allocate a child and link it into the parent
                  next_free_in = next_free_ff + 1'b1;
                  if (node_ff == '0) begin
                     if (step_bit) begin
                        root_one_in = alloc_node;
                     end else begin
                        root_zero_in = alloc_node;
                     end
                  end else begin
                     ram_wr_en = 1'b1;
                     if (step_bit) begin
                        ram_wr_data = {cur_zero, alloc_node, cur_mark, cur_hop};
                     end else begin
                        ram_wr_data = {alloc_node, cur_one, cur_mark, cur_hop};
                     end
                  end
                  node_in  = alloc_node;
                  fresh_in = 1'b1;
                  depth_in = depth_ff + 1'b1;
                  addr_in  = addr_ff << 1;
               end
            end
         end

         ST_DONE: begin
            // load the response register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == btlpm_pkg::CMD_LOOKUP) begin
                  rsp_found_in  = found_ff;
                  rsp_hop_in    = btlpm_pkg::HOP_PORT_W'(best_ff);
                  rsp_status_in = btlpm_pkg::STATUS_OK;
               end else begin
                  rsp_found_in  = 1'b0;
                  rsp_hop_in    = '0;
                  rsp_status_in = status_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         next_free_ff <= CNT_W'(1);
         root_zero_ff <= '0;
         root_one_ff  <= '0;
         root_mark_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_free_ff <= next_free_in;
         root_zero_ff <= root_zero_in;
         root_one_ff  <= root_one_in;
         root_mark_ff <= root_mark_in;
      end
      root_hop_ff   <= root_hop_in;
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      depth_ff      <= depth_in;
      hop_ff        <= hop_in;
      node_ff       <= node_in;
      fresh_ff      <= fresh_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ports
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_hop_out = rsp_hop_ff;
   assign rsp_status  = rsp_status_ff;

endmodule : binary_trie_longest_prefix_match_top

`default_nettype wire

// ===== verif/binary_trie_longest_prefix_match_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_top_tb
// Self-checking bench for the trie route table. A behavioural copy of the
// trie predicts found, hop_out and status for every accepted request, and
// each response is compared in order against it. Directed routes cover the
// empty table, the default route, host routes, over-long prefix lengths,
// nesting and overwrite; random traffic grows prefixes out of known routes,
// and a final pass fills the pool with host routes to drive the pool-full case.
// ----------------------------------------------------------------------------

module binary_trie_longest_prefix_match_top_tb;

   localparam int unsigned TRIE_NODES  = 1024;
   localparam int unsigned ADDR_BITS   = 32;
   localparam int          KNOWN_MAX   = 256;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          DRAIN_WAIT  = 40;

   typedef struct packed {
      logic                             found;
      logic [btlpm_pkg::HOP_PORT_W-1:0] hop_out;
      logic                             status;
   } route_result_type;

   // clock, reset and block ports
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_command = btlpm_pkg::CMD_INSERT;
   logic [btlpm_pkg::ADDR_PORT_W-1:0] req_address = '0;
   logic [btlpm_pkg::LEN_PORT_W-1:0]  req_route_len = '0;
   logic [btlpm_pkg::HOP_PORT_W-1:0]  req_hop_in = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_found;
   logic [btlpm_pkg::HOP_PORT_W-1:0]  rsp_hop_out;
   logic                              rsp_status;

   // predicted trie contents
   int unsigned                       trie_zero_child [TRIE_NODES];
   int unsigned                       trie_one_child  [TRIE_NODES];
   bit                                trie_mark       [TRIE_NODES];
   logic [btlpm_pkg::HOP_PORT_W-1:0]  trie_hop        [TRIE_NODES];
   int unsigned                       trie_next_free = 1;

   // routes known to be stored, used to steer random traffic down real paths
   logic [31:0]            known_addr [KNOWN_MAX];
   int unsigned            known_len  [KNOWN_MAX];
   int                     known_count = 1;

   route_result_type       pending_route_results [$];
   int                     failure_count = 0;
   int                     cycle_count = 0;
   int                     burst_left = 0;

   binary_trie_longest_prefix_match_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_address    (req_address),
      .req_route_len  (req_route_len),
      .req_hop_in     (req_hop_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_hop_out    (rsp_hop_out),
      .rsp_status     (rsp_status)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // mask of the top len address bits
   function automatic logic [31:0] prefix_mask(input int unsigned len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   // trie behaviour: insert walks and allocates, lookup keeps the deepest mark
   function automatic route_result_type route_table_apply(
      input logic                             cmd,
      input logic [31:0]                      addr,
      input logic [btlpm_pkg::LEN_PORT_W-1:0] len_field,
      input logic [btlpm_pkg::HOP_PORT_W-1:0] hop);
      route_result_type res;
      int unsigned      walk_len;
      int unsigned      node;
      int unsigned      nxt;
      int unsigned      depth;
      logic             bit_val;
      res = '0;
      node = 0;
      if (cmd == btlpm_pkg::CMD_INSERT) begin
         walk_len = (len_field > ADDR_BITS) ? ADDR_BITS : len_field;
         for (depth = 0; depth < walk_len; depth++) begin
            bit_val = addr[ADDR_BITS-1-depth];
            nxt = bit_val ? trie_one_child[node] : trie_zero_child[node];
            if (nxt == 0) begin
               if (trie_next_free >= TRIE_NODES) begin
                  res.status = btlpm_pkg::STATUS_POOL_FULL;
                  return res;
               end
               nxt = trie_next_free;
               trie_next_free++;
               trie_zero_child[nxt] = 0;
               trie_one_child[nxt]  = 0;
               trie_mark[nxt]       = 1'b0;
               if (bit_val) trie_one_child[node] = nxt;
               else trie_zero_child[node] = nxt;
            end
            node = nxt;
         end
         trie_mark[node] = 1'b1;
         trie_hop[node]  = hop;
         res.status = btlpm_pkg::STATUS_OK;
      end else begin
         for (depth = 0; depth <= ADDR_BITS; depth++) begin
            if (trie_mark[node]) begin
               res.found   = 1'b1;
               res.hop_out = trie_hop[node];
            end
            if (depth == ADDR_BITS) break;
            node = addr[ADDR_BITS-1-depth] ? trie_one_child[node] : trie_zero_child[node];
            if (node == 0) break;
         end
      end
      return res;
   endfunction

   // keep a stored route for later traffic; slot 0 holds the default route
   function automatic void remember_route(
      input logic [31:0]                      addr,
      input logic [btlpm_pkg::LEN_PORT_W-1:0] len_field);
      int unsigned len;
      int          slot;
      len = (len_field > ADDR_BITS) ? ADDR_BITS : len_field;
      if (known_count < KNOWN_MAX) begin
         slot = known_count;
         known_count++;
      end else begin
         slot = int'($urandom_range(1, KNOWN_MAX - 1));
      end
      known_addr[slot] = addr & prefix_mask(len);
      known_len[slot]  = len;
   endfunction

   // one request transaction, with the sender's bursts and gaps
   task automatic issue_route_command(
      input  logic                             cmd,
      input  logic [31:0]                      addr,
      input  logic [btlpm_pkg::LEN_PORT_W-1:0] len_field,
      input  logic [btlpm_pkg::HOP_PORT_W-1:0] hop,
      output route_result_type                 res);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 40));
         if (gap > 0) begin
            req_valid     <= 1'b0;
            req_command   <= 1'($urandom_range(0, 1));
            req_address   <= $urandom;
            req_route_len <= btlpm_pkg::LEN_PORT_W'($urandom);
            req_hop_in    <= btlpm_pkg::HOP_PORT_W'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(50, 150))
                                                  : int'($urandom_range(1, 12));
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_address   <= addr;
      req_route_len <= len_field;
      req_hop_in    <= hop;
      do @(posedge clock); while (req_stall);
      res = route_table_apply(cmd, addr, len_field, hop);
      pending_route_results.push_back(res);
   endtask

   // lookups on an empty table miss
   task automatic test_empty_table();
      route_result_type res;
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, res);
   endtask

   // zero length prefix marks the root
   task automatic test_default_route();
      route_result_type res;
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'hDEAD_BEEF, 6'd0, 16'hFFFF, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h1234_5678, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd32, 16'h0000, res);
   endtask

   // full length host routes at both address extremes
   task automatic test_host_routes();
      route_result_type res;
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0001, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0000_0000, 6'd32, 16'h8000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'h0000, res);
      remember_route(32'hFFFF_FFFF, 6'd32);
      remember_route(32'h0000_0000, 6'd32);
   endtask

   // prefix lengths above the address width behave as full length
   task automatic test_overlong_prefix();
      route_result_type res;
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'hC0A8_0101, 6'd63, 16'h5A5A, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'hC0A8_0102, 6'd33, 16'hA5A5, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0102, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0100, 6'd0, 16'h0000, res);
      remember_route(32'hC0A8_0101, 6'd32);
   endtask

   // nested prefixes, marking an existing inner node, hop overwrite
   task automatic test_nested_overwrite();
      route_result_type res;
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0A01_0000, 6'd16, 16'h000B, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0A00_0000, 6'd8, 16'h000A, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0A02_0000, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0A00_0000, 6'd8, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0A01_FFFF, 6'd16, 16'h7FFF, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0A02_0000, 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, 32'h0A01_0000, 6'd0, 16'h0000, res);
      remember_route(32'h0A00_0000, 6'd8);
      remember_route(32'h0A01_0000, 6'd16);
   endtask

   // random traffic grown out of stored routes, plus noise
   task automatic test_random_traffic(input int count);
      route_result_type                 res;
      int                               choice;
      int                               k;
      int unsigned                      base_len;
      int unsigned                      new_len;
      logic [31:0]                      base;
      logic [31:0]                      addr;
      logic [btlpm_pkg::LEN_PORT_W-1:0] len_field;
      logic                             cmd;
      repeat (count) begin
         choice   = int'($urandom_range(0, 99));
         k        = int'($urandom_range(0, known_count - 1));
         base     = known_addr[k];
         base_len = known_len[k];
         addr     = (base & prefix_mask(base_len)) | ($urandom & ~prefix_mask(base_len));
         if (choice < 45) begin
            // lookup under a stored prefix, sometimes off the path
            if ($urandom_range(0, 3) == 0) addr = addr ^ (32'h1 << $urandom_range(0, 31));
            if ($urandom_range(0, 9) == 0) addr = $urandom;
            issue_route_command(btlpm_pkg::CMD_LOOKUP, addr,
                                btlpm_pkg::LEN_PORT_W'($urandom),
                                btlpm_pkg::HOP_PORT_W'($urandom), res);
         end else if (choice < 80) begin
            // new route a few levels below a stored one
            new_len = base_len + $urandom_range(0, 8);
            if (new_len > ADDR_BITS) new_len = ADDR_BITS;
            if ($urandom_range(0, 19) == 0) new_len = $urandom_range(0, ADDR_BITS);
            len_field = btlpm_pkg::LEN_PORT_W'(new_len);
            if ($urandom_range(0, 24) == 0) begin
               len_field = btlpm_pkg::LEN_PORT_W'($urandom_range(33, 63));
            end
            issue_route_command(btlpm_pkg::CMD_INSERT, addr, len_field,
                                btlpm_pkg::HOP_PORT_W'($urandom), res);
            if (res.status == btlpm_pkg::STATUS_OK) remember_route(addr, len_field);
         end else if (choice < 95) begin
            // overwrite the hop of a stored route
            issue_route_command(btlpm_pkg::CMD_INSERT, addr,
                                btlpm_pkg::LEN_PORT_W'(base_len),
                                btlpm_pkg::HOP_PORT_W'($urandom), res);
         end else begin
            cmd       = 1'($urandom_range(0, 1));
            addr      = $urandom;
            len_field = btlpm_pkg::LEN_PORT_W'($urandom);
            issue_route_command(cmd, addr, len_field, btlpm_pkg::HOP_PORT_W'($urandom), res);
            if (cmd == btlpm_pkg::CMD_INSERT && res.status == btlpm_pkg::STATUS_OK) begin
               remember_route(addr, len_field);
            end
         end
      end
   endtask

   // host routes until the pool is exhausted, then probe partial paths
   task automatic test_pool_exhaustion();
      route_result_type res;
      int               full_seen;
      int               tries;
      int               k;
      logic [31:0]      addr;
      logic [31:0]      last_full;
      full_seen = 0;
      tries     = 0;
      last_full = 32'h0;
      while (full_seen < 3 && tries < 400) begin
         addr = $urandom;
         issue_route_command(btlpm_pkg::CMD_INSERT, addr, 6'd32,
                             btlpm_pkg::HOP_PORT_W'($urandom), res);
         if (res.status == btlpm_pkg::STATUS_POOL_FULL) begin
            full_seen++;
            last_full = addr;
         end else begin
            remember_route(addr, 6'd32);
         end
         tries++;
      end
      issue_route_command(btlpm_pkg::CMD_LOOKUP, last_full, 6'd0, 16'h0000, res);
      k = int'($urandom_range(0, known_count - 1));
      issue_route_command(btlpm_pkg::CMD_INSERT, known_addr[k],
                          btlpm_pkg::LEN_PORT_W'(known_len[k]), 16'h1234, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, known_addr[k], 6'd0, 16'h0000, res);
      issue_route_command(btlpm_pkg::CMD_INSERT, 32'h0, 6'd0, 16'h0042, res);
      issue_route_command(btlpm_pkg::CMD_LOOKUP, last_full ^ 32'h1, 6'd0, 16'h0000, res);
   endtask

   // receiver stall pattern: free flow, coin flip, heavy stall, toggling
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      forever begin
         mode = int'($urandom_range(0, 3));
         span = int'($urandom_range(20, 200));
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : check_route_results
      route_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_route_results.size() == 0) begin
            $error("response with no request outstanding");
            failure_count++;
         end else begin
            want = pending_route_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               failure_count++;
            end
            if (rsp_hop_out !== want.hop_out) begin
               $error("hop_out: expected 0x%04h, actual 0x%04h", want.hop_out, rsp_hop_out);
               failure_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failure_count++;
            end
         end
      end
   end

   // run limit
   initial begin : cycle_watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // test sequence
   initial begin : test_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_default_route();
      test_host_routes();
      test_overlong_prefix();
      test_nested_overwrite();
      test_random_traffic(1600);
      test_pool_exhaustion();
      req_valid <= 1'b0;
      while (pending_route_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/btlpm_pkg.sv
hw/rtl/btlpm_ram.sv
hw/rtl/binary_trie_longest_prefix_match_top.sv
verif/binary_trie_longest_prefix_match_top_tb.sv
